// ===== rtl/ms_pkg.sv =====
// Shared types and codes for the merge sorter.
package ms_pkg;

  // Key width (signed Q16.16)
  localparam int KEY_W = 32;

  // Request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Read status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_MINIT = 8'b0000_0100,
    S_LDA   = 8'b0000_1000,
    S_LDB   = 8'b0001_0000,
    S_CMP   = 8'b0010_0000,
    S_FA    = 8'b0100_0000,
    S_FB    = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/ms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/merge_sorter.sv =====
// Stable ascending merge sorter for signed Q16.16 keys, top level.
//
// Requests arrive on the input channel (in_valid / in_stall); opcode 0 loads
// key_value into the current set, opcode 1 reads the next sorted value.
// A load with ends_set closes the set and starts a bottom-up merge sort.
// Loads past MAX_ITEMS are dropped; reads of that set then report status 2.
// Reads return one result on the output channel (out_valid / out_stall):
// sorted_value, is_final on the last value, and read_status (1 when there
// is nothing to give, in which case the value is 0).
// A load that fits is written to memory as it is taken. A non-empty read
// passes through the READ state, which puts the registered memory data in
// the output register; an empty read fills it directly. The next request
// can be taken in the cycle after the result leaves. A request is taken
// only when the controller is idle and the output register is empty, so a
// stalled result holds input off. The sort runs ceil(log2(n)) passes over
// the n loaded items, ping-ponging between two memories. Each merge sets up
// in MINIT, LDA and LDB, then per element compares and writes in CMP and,
// if that run has more, gets its next head in FA or FB via the one read port.
// Reset clears the count, read pointer and flags; memory contents are not
// cleared since only entries below the count are ever read.
module merge_sorter #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            opcode,
  input  logic signed [ms_pkg::KEY_W-1:0] key_value,
  input  logic                            ends_set,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ms_pkg::KEY_W-1:0] sorted_value,
  output logic                            is_final,
  output logic [1:0]                      read_status
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = CW + 2;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  ms_pkg::state_t state;

  logic [CW-1:0] item_count;
  logic [CW-1:0] read_pointer;
  logic          set_sorted;
  logic          overflow_seen;
  logic          src_sel;       // memory holding the current data (0 = A)

  // Merge bookkeeping
  logic [PW-1:0] run_width;
  logic [PW-1:0] lo, mid, hi;
  logic [PW-1:0] pos_i, pos_j, pos_k;
  logic signed [ms_pkg::KEY_W-1:0] head_a, head_b;

  // Pending read result
  logic       pend_final;
  logic [1:0] pend_status;

  // Memory ports
  logic                     wr_en, wr_b;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [ms_pkg::KEY_W-1:0] wr_data, rdata_a, rdata_b, rdata;

  logic          accept, take_a;
  logic [CW-1:0] cur_count;
  logic [PW-1:0] n_ext, lo_w, lo_2w, mid_next, hi_next, width_next;

  assign in_stall  = (state != ms_pkg::S_IDLE) || out_valid;
  assign accept    = in_valid && !in_stall;
  assign cur_count = set_sorted ? '0 : item_count;
  assign rdata     = src_sel ? rdata_b : rdata_a;

  // Run bounds
  assign n_ext      = PW'(item_count);
  assign lo_w       = lo + run_width;
  assign lo_2w      = lo + (run_width << 1);
  assign mid_next   = (lo_w < n_ext) ? lo_w : n_ext;
  assign hi_next    = (lo_2w < n_ext) ? lo_2w : n_ext;
  assign width_next = run_width << 1;

  // Left run wins ties, which keeps the sort stable
  assign take_a = (pos_i < mid) && ((pos_j >= hi) || (head_a <= head_b));

  // Memory port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_b    = src_sel;
    wr_addr = cur_count[AW-1:0];
    wr_data = key_value;
    rd_addr = read_pointer[AW-1:0];
    case (state)
      ms_pkg::S_IDLE: begin
        wr_en = accept && (opcode == ms_pkg::OP_LOAD) && (cur_count < MAX_C);
      end
      ms_pkg::S_MINIT: begin
        rd_addr = lo[AW-1:0];
      end
      ms_pkg::S_LDA: begin
        rd_addr = pos_j[AW-1:0];
      end
      ms_pkg::S_CMP: begin
        wr_en   = 1'b1;
        wr_b    = !src_sel;
        wr_addr = pos_k[AW-1:0];
        wr_data = take_a ? head_a : head_b;
        rd_addr = take_a ? pos_i[AW-1:0] + AW'(1) : pos_j[AW-1:0] + AW'(1);
      end
      default: begin
      end
    endcase
  end

  ms_ram #(.WIDTH(ms_pkg::KEY_W), .DEPTH(MAX_ITEMS)) u_ram_a (
    .clk   (clk),
    .we    (wr_en && !wr_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata_a)
  );

  ms_ram #(.WIDTH(ms_pkg::KEY_W), .DEPTH(MAX_ITEMS)) u_ram_b (
    .clk   (clk),
    .we    (wr_en && wr_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata_b)
  );

  // Control and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ms_pkg::S_IDLE;
      item_count    <= '0;
      read_pointer  <= '0;
      set_sorted    <= 1'b0;
      overflow_seen <= 1'b0;
      src_sel       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ms_pkg::S_IDLE: begin
          if (accept && (opcode == ms_pkg::OP_LOAD)) begin
            // A load after a finished sort opens a new set
            if (set_sorted || ends_set) begin
              read_pointer <= '0;
            end
            if (cur_count < MAX_C) begin
              item_count <= cur_count + CW'(1);
              if (set_sorted) begin
                overflow_seen <= 1'b0;
              end
            end else begin
              overflow_seen <= 1'b1;
            end
            // A one-item set needs no sort
            set_sorted <= ends_set && (cur_count == '0);
            if (ends_set) begin
              run_width <= PW'(1);
              lo        <= '0;
              if (cur_count != '0) begin
                state <= ms_pkg::S_MINIT;
              end
            end
          end else if (accept) begin
            if (!set_sorted || (read_pointer >= item_count)) begin
              out_valid    <= 1'b1;
              sorted_value <= '0;
              is_final     <= 1'b0;
              read_status  <= ms_pkg::ST_EMPTY;
            end else begin
              pend_final   <= (read_pointer + CW'(1)) == item_count;
              pend_status  <= overflow_seen ? ms_pkg::ST_DROPPED : ms_pkg::ST_OK;
              read_pointer <= read_pointer + CW'(1);
              state        <= ms_pkg::S_READ;
            end
          end
        end
        ms_pkg::S_READ: begin
          out_valid    <= 1'b1;
          sorted_value <= rdata;
          is_final     <= pend_final;
          read_status  <= pend_status;
          state        <= ms_pkg::S_IDLE;
        end
        ms_pkg::S_MINIT: begin
          mid   <= mid_next;
          hi    <= hi_next;
          pos_i <= lo;
          pos_j <= mid_next;
          pos_k <= lo;
          state <= ms_pkg::S_LDA;
        end
        ms_pkg::S_LDA: begin
          head_a <= rdata;
          state  <= ms_pkg::S_LDB;
        end
        ms_pkg::S_LDB: begin
          head_b <= rdata;
          state  <= ms_pkg::S_CMP;
        end
        ms_pkg::S_CMP: begin
          pos_k <= pos_k + PW'(1);
          if (take_a) begin
            pos_i <= pos_i + PW'(1);
          end else begin
            pos_j <= pos_j + PW'(1);
          end
          if ((pos_k + PW'(1)) == hi) begin
            // Merge done: next pair of runs, next pass, or finish
            if (lo_2w >= n_ext) begin
              src_sel   <= !src_sel;
              run_width <= width_next;
              lo        <= '0;
              if (width_next >= n_ext) begin
                set_sorted <= 1'b1;
                state      <= ms_pkg::S_IDLE;
              end else begin
                state <= ms_pkg::S_MINIT;
              end
            end else begin
              lo    <= lo_2w;
              state <= ms_pkg::S_MINIT;
            end
          end else if (take_a && ((pos_i + PW'(1)) < mid)) begin
            state <= ms_pkg::S_FA;
          end else if (!take_a && ((pos_j + PW'(1)) < hi)) begin
            state <= ms_pkg::S_FB;
          end
        end
        // Wait out the read latency before the next compare
        ms_pkg::S_FA: begin
          head_a <= rdata;
          state  <= ms_pkg::S_CMP;
        end
        ms_pkg::S_FB: begin
          head_b <= rdata;
          state  <= ms_pkg::S_CMP;
        end
        default: begin
          state <= ms_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Merge writes stay inside the current pair of runs
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ms_pkg::S_CMP) |-> (pos_k < hi) && (pos_k >= lo))
    else $error("merge write outside run range");

  // Compare only with at least one run non-empty and heads within bounds
  a_runs_live: assert property (@(posedge clk) disable iff (rst)
    (state == ms_pkg::S_CMP) |-> ((pos_i < mid) || (pos_j < hi)) &&
                                 (pos_i <= mid) && (pos_j <= hi))
    else $error("merge compare with exhausted runs");

  // Count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    item_count <= MAX_C)
    else $error("item count above capacity");

  // A result appears only after a read request or a memory read
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ms_pkg::S_READ) ||
                         $past(accept && (opcode == ms_pkg::OP_READ)))
    else $error("result without read request");

  // The sorted flag is never up while a sort is still running
  a_sorted_idle: assert property (@(posedge clk) disable iff (rst)
    set_sorted |-> (state == ms_pkg::S_IDLE) || (state == ms_pkg::S_READ))
    else $error("set flagged sorted during sort");

endmodule

// ===== tb/merge_sorter_test.sv =====
// Self-checking testbench for the merge sorter: loads sets, reads them back, predicts each read.
`timescale 1ns / 100ps

module merge_sorter_test;

  localparam int CAPACITY    = 1024;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [ms_pkg::KEY_W-1:0] MIN_KEY = {1'b1, {(ms_pkg::KEY_W-1){1'b0}}};
  localparam logic signed [ms_pkg::KEY_W-1:0] MAX_KEY = {1'b0, {(ms_pkg::KEY_W-1){1'b1}}};
  localparam logic signed [ms_pkg::KEY_W-1:0] ONE_Q16 = 32'sh0001_0000;

  typedef struct {
    logic signed [ms_pkg::KEY_W-1:0] value;
    logic                            fin;
    logic [1:0]                      status;
  } read_result_t;

  // Tracks the loaded set, sorts it on close and queues the expected read results
  class sort_tracker;
    logic signed [ms_pkg::KEY_W-1:0] held_keys[$];
    read_result_t                    expected_reads[$];
    int                              read_pos;
    bit                              set_closed;
    bit                              loads_dropped;
    int                              errors;

    function new();
      read_pos      = 0;
      set_closed    = 0;
      loads_dropped = 0;
      errors        = 0;
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction

    function void note_request(logic op, logic signed [ms_pkg::KEY_W-1:0] key, logic ends);
      read_result_t                    r;
      logic signed [ms_pkg::KEY_W-1:0] k;
      int                              j;
      if (op == ms_pkg::OP_LOAD) begin
        // load after a sorted set opens a new one
        if (set_closed) begin
          held_keys.delete();
          read_pos      = 0;
          set_closed    = 0;
          loads_dropped = 0;
        end
        if (held_keys.size() < CAPACITY) held_keys.insert(held_keys.size(), key);
        else loads_dropped = 1;
        if (ends) begin
          // stable insertion sort, ascending
          for (int i = 1; i < held_keys.size(); i++) begin
            k = held_keys[i];
            j = i - 1;
            while (j >= 0 && held_keys[j] > k) begin
              held_keys[j+1] = held_keys[j];
              j--;
            end
            held_keys[j+1] = k;
          end
          read_pos   = 0;
          set_closed = 1;
        end
      end else begin
        if (!set_closed || read_pos >= held_keys.size()) begin
          r.value  = '0;
          r.fin    = 1'b0;
          r.status = ms_pkg::ST_EMPTY;
        end else begin
          r.value  = held_keys[read_pos];
          r.fin    = (read_pos + 1 == held_keys.size());
          r.status = loads_dropped ? ms_pkg::ST_DROPPED : ms_pkg::ST_OK;
          read_pos++;
        end
        expected_reads.insert(expected_reads.size(), r);
      end
    endfunction

    function void check_result(logic signed [ms_pkg::KEY_W-1:0] value, logic fin,
                               logic [1:0] status);
      read_result_t want;
      if (expected_reads.size() == 0) begin
        $error("result with no read pending: sorted_value %0d", value);
        errors++;
        return;
      end
      want = expected_reads.pop_front();
      if (value !== want.value) begin
        $error("sorted_value: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (fin !== want.fin) begin
        $error("is_final: expected %0d, actual %0d", want.fin, fin);
        errors++;
      end
      if (status !== want.status) begin
        $error("read_status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            opcode = ms_pkg::OP_LOAD;
  logic signed [ms_pkg::KEY_W-1:0] key_value = '0;
  logic                            ends_set = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [ms_pkg::KEY_W-1:0] sorted_value;
  logic                            is_final;
  logic [1:0]                      read_status;

  sort_tracker sb;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          requests_sent  = 0;
  int          hold_tickets   = 0;
  int          holds_served   = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;

  merge_sorter #(.MAX_ITEMS(CAPACITY)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .key_value    (key_value),
    .ends_set     (ends_set),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .is_final     (is_final),
    .read_status  (read_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request, with an optional idle gap first; returns once accepted
  task automatic send_request(input logic op, input logic signed [ms_pkg::KEY_W-1:0] key,
                              input logic ends);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    key_value <= key;
    ends_set  <= ends;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, key, ends);
    requests_sent++;
  endtask

  task automatic send_read();
    send_request(ms_pkg::OP_READ, $urandom, 1'($urandom_range(1)));
  endtask

  // Sender goes quiet until every pending read has returned
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [ms_pkg::KEY_W-1:0] pick_key();
    int v;
    v = $urandom_range(6);
    case ($urandom_range(9))
      0:       return MIN_KEY;
      1:       return MAX_KEY;
      2:       return v - 3;
      3:       return (v - 3) * ONE_Q16;
      default: return $urandom;
    endcase
  endfunction

  // Mostly whole sets read back in full; some truncated reads and loose noise
  task automatic run_random_sets(input int quota);
    int goal;
    int size;
    int reads;
    goal = requests_sent + quota;
    while (requests_sent < goal) begin
      if ($urandom_range(99) < 80) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        for (int i = 0; i < size; i++) begin
          if ($urandom_range(19) == 0) send_read();
          send_request(ms_pkg::OP_LOAD, pick_key(), i == size - 1);
        end
        reads = ($urandom_range(4) == 0) ? $urandom_range(0, size) : size + $urandom_range(0, 2);
        repeat (reads) send_read();
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(($urandom_range(1) != 0) ? ms_pkg::OP_READ : ms_pkg::OP_LOAD,
                       pick_key(), 1'($urandom_range(1)));
      end
    end
  endtask

  // Result side: check each accepted result, then pick next cycle's stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(sorted_value, is_final, read_status);
    end
    if (hold_tickets != holds_served) begin
      holds_served = hold_tickets;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // read before any set exists
    send_request(ms_pkg::OP_READ, $urandom, 1'b1);
    // extremes and a duplicate, then read past the end
    send_request(ms_pkg::OP_LOAD, MAX_KEY, 1'b0);
    send_request(ms_pkg::OP_LOAD, MIN_KEY, 1'b0);
    send_request(ms_pkg::OP_LOAD, '0, 1'b0);
    send_request(ms_pkg::OP_LOAD, -1, 1'b0);
    send_request(ms_pkg::OP_LOAD, 1, 1'b0);
    send_request(ms_pkg::OP_LOAD, MIN_KEY, 1'b0);
    send_request(ms_pkg::OP_LOAD, ONE_Q16, 1'b1);
    repeat (8) send_read();
    // single-item set opened by a load after sort
    send_request(ms_pkg::OP_LOAD, 32'sd5, 1'b1);
    repeat (2) send_read();
    // read while loading, then a new set cut in mid-read
    send_request(ms_pkg::OP_LOAD, 32'sd3, 1'b0);
    send_read();
    send_request(ms_pkg::OP_LOAD, -32'sd3, 1'b1);
    send_read();
    send_request(ms_pkg::OP_LOAD, 32'sd7, 1'b1);
    send_read();
    send_read();
    drain_results();

    // long receiver hold-off while reads keep coming, so the input backs up
    for (int i = 0; i < 8; i++) send_request(ms_pkg::OP_LOAD, pick_key(), i == 7);
    hold_tickets++;
    repeat (10) send_read();
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      run_random_sets(105);
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
